[src/oal_pkg.sv]
// Package for the ordered array list unit: request and response item types,
// operation and status codes, and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package oal_pkg;

  localparam int OAL_CAPACITY = 64;

  localparam int MODE_W  = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;
  localparam int STAT_W  = 2;
  localparam int FIDX_W  = 6;
  localparam int COUNT_W = 7;

  localparam logic [MODE_W-1:0] MODE_APPEND     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_GET        = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE_AT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE_VAL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FIND       = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } oal_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic signed [VALUE_W-1:0] data;
    logic [FIDX_W-1:0]         found_index;
    logic [COUNT_W-1:0]        count;
  } oal_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GET,
    ST_SCAN,
    ST_SHIFT,
    ST_FINISH
  } oal_state_t;

endpackage

`default_nettype wire

[src/oal_seq.sv]
// Sequencer of the ordered array list: entry memory, entry count, the read and
// write pointers and the shared compare unit that walks the stored entries.
// Depends on oal_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oal_seq #(
  parameter int CAPACITY = oal_pkg::OAL_CAPACITY
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              req_valid,
  output logic             req_ready,
  input  oal_pkg::oal_req_t req,
  output logic             res_valid,
  input  wire              res_ready,
  output oal_pkg::oal_rsp_t res
);
  import oal_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rdata;

  oal_state_t state, state_next;

  logic [CW-1:0]      count;
  logic [CW-1:0]      rptr;
  logic [AW-1:0]      wptr;
  logic [AW-1:0]      pidx;
  logic               pend;
  logic               remove_op;
  logic [VALUE_W-1:0] key;
  logic [STAT_W-1:0]  res_status;
  logic [VALUE_W-1:0] res_data;
  logic [AW-1:0]      res_fidx;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;
  logic [AW-1:0]      raddr;

  logic accept;
  logic pos_ok;
  logic not_full;
  logic rd_more;
  logic hit;

  assign accept   = req_valid && req_ready;
  assign pos_ok   = CMPW'(req.position) < CMPW'(count);
  assign not_full = count < CW'(CAPACITY);
  assign rd_more  = rptr < count;
  assign hit      = pend && (rdata == key);

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.mode)
            MODE_GET:        state_next = pos_ok ? ST_GET : ST_FINISH;
            MODE_REMOVE_AT:  state_next = pos_ok ? ST_SHIFT : ST_FINISH;
            MODE_REMOVE_VAL: state_next = ST_SCAN;
            MODE_FIND:       state_next = ST_SCAN;
            default:         state_next = ST_FINISH;
          endcase
        end
      end
      ST_GET: state_next = ST_FINISH;
      ST_SCAN: begin
        if (hit) begin
          state_next = remove_op ? ST_SHIFT : ST_FINISH;
        end else if (!rd_more) begin
          state_next = ST_FINISH;
        end
      end
      ST_SHIFT: begin
        if (!rd_more && !pend) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    res_valid = 1'b0;
    we        = 1'b0;
    waddr     = wptr;
    wdata     = rdata;
    raddr     = AW'(rptr);
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        raddr     = AW'(req.position);
        waddr     = AW'(count);
        wdata     = req.value;
        we        = req_valid && (req.mode == MODE_APPEND) && not_full;
      end
      ST_SHIFT: begin
        // The word read in the previous cycle lands one place lower.
        we = pend;
      end
      ST_FINISH: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_data   <= '0;
            res_fidx   <= '0;
            key        <= req.value;
            remove_op  <= (req.mode == MODE_REMOVE_VAL);
            pend       <= 1'b0;
            case (req.mode)
              MODE_APPEND: begin
                res_status <= not_full ? STAT_OK : STAT_FULL;
                rptr       <= '0;
                if (not_full) begin
                  count <= count + 1'b1;
                end
              end
              MODE_GET: begin
                res_status <= pos_ok ? STAT_OK : STAT_RANGE;
                rptr       <= '0;
              end
              MODE_REMOVE_AT: begin
                res_status <= pos_ok ? STAT_OK : STAT_RANGE;
                rptr       <= CW'(req.position) + 1'b1;
                wptr       <= AW'(req.position);
              end
              MODE_CLEAR: begin
                res_status <= STAT_OK;
                rptr       <= '0;
                count      <= '0;
              end
              default: begin
                res_status <= STAT_OK;
                rptr       <= '0;
              end
            endcase
          end
        end
        ST_GET: res_data <= rdata;
        ST_SCAN: begin
          if (hit) begin
            res_fidx <= pidx;
            // Start the shift at the match; the read still in flight is dropped.
            rptr <= CW'(pidx) + 1'b1;
            wptr <= pidx;
            pend <= 1'b0;
          end else begin
            if (!rd_more) begin
              res_status <= STAT_NOT_FOUND;
            end else begin
              rptr <= rptr + 1'b1;
            end
            pend <= rd_more;
            pidx <= AW'(rptr);
          end
        end
        ST_SHIFT: begin
          if (rd_more) begin
            rptr <= rptr + 1'b1;
          end
          if (pend) begin
            wptr <= wptr + 1'b1;
          end
          pend <= rd_more;
          if (!rd_more && !pend) begin
            count <= count - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign res.status      = res_status;
  assign res.data        = res_data;
  assign res.found_index = FIDX_W'(res_fidx);
  assign res.count       = COUNT_W'(count);

endmodule

`default_nettype wire

[src/ordered_array_list_unit.sv]
// Ordered array list unit: one request item in, one response item out.
// Append, clear, unused modes and a refused get or remove walk no entries. Get reads one;
// find walks up to a match; remove at a position shifts the entries above it down; remove
// by value walks to the match, then shifts the rest. Entries are walked one per cycle.
// A new item is taken while the previous response still waits in its register.
// Reset (synchronous) empties the list; entry contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module ordered_array_list_unit #(
  parameter int CAPACITY = oal_pkg::OAL_CAPACITY
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               req_valid,
  output logic              req_ready,
  input  oal_pkg::oal_req_t req,
  output logic              rsp_valid,
  input  wire               rsp_ready,
  output oal_pkg::oal_rsp_t rsp
);
  import oal_pkg::*;

  oal_rsp_t res;
  logic     res_valid;
  logic     res_ready;

  oal_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire

[src/oal_checker.sv]
// Port-level checks for the ordered array list unit, bound to the top level.
// Depends on oal_pkg and ordered_array_list_unit.
`timescale 1ns / 1ps
`default_nettype none

module oal_checker (
  input wire               clk,
  input wire               rst,
  input wire               req_valid,
  input wire               req_ready,
  input oal_pkg::oal_req_t req,
  input wire               rsp_valid,
  input wire               rsp_ready,
  input oal_pkg::oal_rsp_t rsp
);
  import oal_pkg::*;

  // Only one item is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while an item is still in work");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> req_ready && !rsp_valid)
    else $error("not idle after reset");

  // A response is loaded only at the end of an item's work, when no request is taken.
  a_rsp_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("response appeared without an item in work");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

endmodule

bind ordered_array_list_unit oal_checker u_oal_checker (.*);

`default_nettype wire

[verif/tb.sv]
// Testbench for ordered_array_list_unit: a short stimulus table, then random
// list traffic; each response is checked against its table row or a list
// model kept here. Depends on oal_pkg and the ordered_array_list_unit RTL.
`timescale 1ns / 1ps

module tb;
  import oal_pkg::*;

  localparam int CAP        = OAL_CAPACITY;
  localparam int CAP_AW     = $clog2(CAP);
  localparam int N_RANDOM   = 1280;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 100;

  localparam logic [VALUE_W-1:0] VMIN  = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VMAX  = 32'h7fff_ffff;
  localparam logic [VALUE_W-1:0] VONES = 32'hffff_ffff;
  localparam logic [VALUE_W-1:0] VZERO = 32'h0000_0000;

  localparam logic [MODE_W-1:0] MODE_UNUSED_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_B = 3'd7;

  localparam logic [STAT_W+VALUE_W+FIDX_W+COUNT_W-1:0] NO_RSP = '0;

  typedef struct packed {
    logic     has_rsp;
    oal_req_t req;
    oal_rsp_t rsp;
  } dir_row_t;

  // Rows with has_rsp set carry a response read straight off the list rules;
  // the rest are checked against the list model.
  dir_row_t dir_tbl [0:24] = '{
    {1'b1, MODE_GET,        VZERO, 6'd0,  STAT_RANGE,     VZERO, 6'd0, 7'd0},
    {1'b1, MODE_REMOVE_AT,  VZERO, 6'd63, STAT_RANGE,     VZERO, 6'd0, 7'd0},
    {1'b1, MODE_FIND,       VZERO, 6'd0,  STAT_NOT_FOUND, VZERO, 6'd0, 7'd0},
    {1'b1, MODE_REMOVE_VAL, VONES, 6'd0,  STAT_NOT_FOUND, VZERO, 6'd0, 7'd0},
    {1'b1, MODE_APPEND,     VMIN,  6'd63, STAT_OK,        VZERO, 6'd0, 7'd1},
    {1'b1, MODE_APPEND,     VMAX,  6'd0,  STAT_OK,        VZERO, 6'd0, 7'd2},
    {1'b1, MODE_APPEND,     VONES, 6'd0,  STAT_OK,        VZERO, 6'd0, 7'd3},
    {1'b1, MODE_APPEND,     VZERO, 6'd0,  STAT_OK,        VZERO, 6'd0, 7'd4},
    {1'b1, MODE_APPEND,     VMAX,  6'd0,  STAT_OK,        VZERO, 6'd0, 7'd5},
    {1'b1, MODE_GET,        VZERO, 6'd0,  STAT_OK,        VMIN,  6'd0, 7'd5},
    {1'b1, MODE_GET,        VZERO, 6'd4,  STAT_OK,        VMAX,  6'd0, 7'd5},
    {1'b1, MODE_GET,        VZERO, 6'd5,  STAT_RANGE,     VZERO, 6'd0, 7'd5},
    {1'b1, MODE_GET,        VMAX,  6'd63, STAT_RANGE,     VZERO, 6'd0, 7'd5},
    {1'b1, MODE_FIND,       VMAX,  6'd0,  STAT_OK,        VZERO, 6'd1, 7'd5},
    {1'b1, MODE_FIND,       32'h0000_5a5a, 6'd0, STAT_NOT_FOUND, VZERO, 6'd0, 7'd5},
    {1'b1, MODE_UNUSED_A,   VMAX,  6'd63, STAT_OK,        VZERO, 6'd0, 7'd5},
    {1'b1, MODE_UNUSED_B,   VONES, 6'd63, STAT_OK,        VZERO, 6'd0, 7'd5},
    {1'b0, MODE_REMOVE_VAL, VMAX,  6'd0,  NO_RSP},
    {1'b0, MODE_FIND,       VMAX,  6'd0,  NO_RSP},
    {1'b0, MODE_REMOVE_AT,  VZERO, 6'd0,  NO_RSP},
    {1'b0, MODE_GET,        VZERO, 6'd2,  NO_RSP},
    {1'b0, MODE_REMOVE_AT,  VZERO, 6'd2,  NO_RSP},
    {1'b1, MODE_CLEAR,      VONES, 6'd63, STAT_OK,        VZERO, 6'd0, 7'd0},
    {1'b1, MODE_GET,        VZERO, 6'd0,  STAT_RANGE,     VZERO, 6'd0, 7'd0},
    {1'b0, MODE_FIND,       VMIN,  6'd0,  NO_RSP}
  };

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     rsp_ready = 1'b0;
  oal_req_t req       = '0;
  logic     req_ready;
  logic     rsp_valid;
  oal_rsp_t rsp;

  // List model and the expected responses that have not yet been seen.
  logic [VALUE_W-1:0] lst_mem [0:CAP-1];
  int                 lst_cnt = 0;
  oal_rsp_t           rsp_expected_q [$];
  oal_rsp_t           want;

  logic [VALUE_W-1:0] val_pool [0:7];
  int errors      = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  int rdy_left    = 0;
  int rdy_style   = 0;

  ordered_array_list_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #10 clk = ~clk;

  function automatic oal_rsp_t apply_request(input oal_req_t r);
    oal_rsp_t o;
    int hit;
    int gone;
    int i;
    o = '0;
    hit = -1;
    gone = -1;
    for (i = lst_cnt - 1; i >= 0; i--)
      if (lst_mem[CAP_AW'(i)] == r.value) hit = i;
    case (r.mode)
      MODE_APPEND: begin
        if (lst_cnt == CAP) begin
          o.status = STAT_FULL;
        end else begin
          lst_mem[CAP_AW'(lst_cnt)] = r.value;
          lst_cnt++;
        end
      end
      MODE_GET: begin
        if (int'(r.position) < lst_cnt) o.data = lst_mem[r.position];
        else o.status = STAT_RANGE;
      end
      MODE_REMOVE_AT: begin
        if (int'(r.position) < lst_cnt) gone = int'(r.position);
        else o.status = STAT_RANGE;
      end
      MODE_REMOVE_VAL: begin
        if (hit >= 0) begin
          o.found_index = hit[FIDX_W-1:0];
          gone = hit;
        end else begin
          o.status = STAT_NOT_FOUND;
        end
      end
      MODE_FIND: begin
        if (hit >= 0) o.found_index = hit[FIDX_W-1:0];
        else o.status = STAT_NOT_FOUND;
      end
      MODE_CLEAR: lst_cnt = 0;
      default: ;
    endcase
    if (gone >= 0) begin
      for (i = gone; i < lst_cnt - 1; i++) lst_mem[CAP_AW'(i)] = lst_mem[CAP_AW'(i + 1)];
      lst_cnt--;
    end
    o.count = lst_cnt[COUNT_W-1:0];
    return o;
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return MODE_APPEND;
    if (roll < 45) return MODE_GET;
    if (roll < 57) return MODE_REMOVE_AT;
    if (roll < 69) return MODE_REMOVE_VAL;
    if (roll < 87) return MODE_FIND;
    if (roll < 90) return MODE_CLEAR;
    if (roll < 95) return roll[0] ? MODE_UNUSED_A : MODE_UNUSED_B;
    return MODE_APPEND;
  endfunction

  // Searches mostly use values that are really in the list so that hits land
  // at every depth; the rest come from a small pool, the extremes, or anywhere.
  function automatic oal_req_t build_req(input logic [MODE_W-1:0] m);
    oal_req_t r;
    int roll;
    r.mode = m;
    roll = $urandom_range(0, 9);
    if ((m == MODE_FIND || m == MODE_REMOVE_VAL) && lst_cnt > 0 && roll < 6)
      r.value = lst_mem[CAP_AW'($urandom_range(0, lst_cnt - 1))];
    else if (roll < 5)
      r.value = val_pool[3'($urandom_range(0, 7))];
    else if (roll == 5)
      case ($urandom_range(0, 3))
        0: r.value = VMIN;
        1: r.value = VMAX;
        2: r.value = VONES;
        default: r.value = VZERO;
      endcase
    else
      r.value = $urandom();
    if (lst_cnt > 0 && $urandom_range(0, 3) != 0)
      r.position = POS_W'($urandom_range(0, lst_cnt - 1));
    else
      r.position = POS_W'($urandom_range(0, CAP - 1));
    return r;
  endfunction

  // Offers one item and records its prediction once it is taken. The sender
  // runs in bursts; between bursts valid drops for a random gap.
  task automatic push_item(input oal_req_t r, input logic has_rsp, input oal_rsp_t typed);
    oal_rsp_t pred;
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pred = apply_request(r);
    rsp_expected_q.push_back(has_rsp ? typed : pred);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (rsp_expected_q.size() != 0) @(posedge clk);
  endtask

  // The receiver mixes always ready, coin flips, long stalls, mostly ready.
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_style <= $urandom_range(0, 3);
      rdy_left <= $urandom_range(20, 200);
    end else begin
      rdy_left <= rdy_left - 1;
    end
    case (rdy_style)
      0: rsp_ready <= 1'b1;
      1: rsp_ready <= 1'($urandom_range(0, 1));
      2: rsp_ready <= ($urandom_range(0, 7) == 0);
      default: rsp_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (rsp_expected_q.size() == 0) begin
        errors++;
        $display("%0t: response with none expected: %p", $time, rsp);
      end else begin
        want = rsp_expected_q.pop_front();
        if (rsp.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, want.status, rsp.status);
        end
        if (rsp.data !== want.data) begin
          errors++;
          $display("%0t: data expected %h got %h", $time, want.data, rsp.data);
        end
        if (rsp.found_index !== want.found_index) begin
          errors++;
          $display("%0t: found_index expected %0d got %0d", $time, want.found_index,
                   rsp.found_index);
        end
        if (rsp.count !== want.count) begin
          errors++;
          $display("%0t: count expected %0d got %0d", $time, want.count, rsp.count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("FAIL ordered_array_list_unit");
      $finish;
    end
  end

  initial begin
    int n_sent;
    int episode;
    oal_req_t r;
    n_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[i]) push_item(dir_tbl[i].req, dir_tbl[i].has_rsp, dir_tbl[i].rsp);
    wait_drained();

    while (n_sent < N_RANDOM) begin
      foreach (val_pool[k])
        val_pool[k] = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 15);
      episode = $urandom_range(0, 9);
      if (episode < 6) begin
        repeat ($urandom_range(10, 60)) begin
          push_item(build_req(pick_mode()), 1'b0, '0);
          n_sent++;
        end
      end else if (episode < 8) begin
        // Fill the list, push past full, then work on the full list.
        while (lst_cnt < CAP) begin
          push_item(build_req(MODE_APPEND), 1'b0, '0);
          n_sent++;
        end
        repeat ($urandom_range(1, 3)) begin
          push_item(build_req(MODE_APPEND), 1'b0, '0);
          n_sent++;
        end
        r = build_req(MODE_GET);
        r.position = POS_W'(CAP - 1);
        push_item(r, 1'b0, '0);
        repeat ($urandom_range(2, 10)) begin
          push_item(build_req(pick_mode()), 1'b0, '0);
          n_sent++;
        end
      end else begin
        // Empty the list by removals, then touch it while empty.
        while (lst_cnt > 0) begin
          push_item(build_req($urandom_range(0, 1) ? MODE_REMOVE_AT : MODE_REMOVE_VAL),
                    1'b0, '0);
          n_sent++;
        end
        push_item(build_req(MODE_GET), 1'b0, '0);
        push_item(build_req(MODE_REMOVE_AT), 1'b0, '0);
        push_item(build_req(MODE_FIND), 1'b0, '0);
        n_sent += 3;
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0)
      $display("PASS ordered_array_list_unit");
    else
      $display("FAIL ordered_array_list_unit");
    $finish;
  end

endmodule
